@@ src/flv_tag_check_timeline_top_assert.svh @@
// assertion macros shared by the flv tag checker
`ifndef FLV_TAG_CHECK_TIMELINE_TOP_ASSERT_SVH
`define FLV_TAG_CHECK_TIMELINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define FLVTC_ASSERT_NOW(label, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("flvtc check failed");

// next-cycle implication, sampled on clk, off during reset
`define FLVTC_ASSERT_NEXT(label, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("flvtc check failed");

`else

`define FLVTC_ASSERT_NOW(label, ant, cons)
`define FLVTC_ASSERT_NEXT(label, ant, cons)

`endif

`endif

@@ src/flvtc_pkg.sv @@
package flvtc_pkg;

    localparam int MAX_RANGES_DEF = 32;

    localparam logic [7:0]  TYPE_AUDIO    = 8'h08;
    localparam logic [7:0]  TYPE_VIDEO    = 8'h09;
    localparam logic [7:0]  TYPE_META     = 8'h12;
    localparam logic [32:0] TAG_OVERHEAD  = 33'd15;
    localparam logic [31:0] TRAILER_DELTA = 32'd11;

    localparam logic [23:0] GAP_THRESHOLD_RESET = 24'd500;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_TYPE    = 2'd1;
    localparam logic [1:0] ERR_END     = 2'd2;
    localparam logic [1:0] ERR_TRAILER = 2'd3;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_THRESHOLD = 4'd1;

    typedef struct packed {
        logic [31:0] tag_offset;
        logic [7:0]  tag_type;
        logic [23:0] body_length;
        logic [23:0] timestamp_ms;
        logic [31:0] trailer_size;
    } tag_item_t;

    typedef struct packed {
        logic        tag_ok;
        logic [1:0]  error_code;
        logic [31:0] next_offset;
        logic        end_reached;
    } chk_res_t;

    typedef struct packed {
        logic        gap_found;
        logic [23:0] gap_ms;
        logic [4:0]  range_index;
        logic [23:0] range_min;
        logic [23:0] range_max;
        logic        range_overflow;
    } tl_res_t;

endpackage

@@ src/flvtc_tag_if.sv @@
interface flvtc_tag_if;
    logic        valid;
    logic        ready;
    logic [31:0] tag_offset;
    logic [7:0]  tag_type;
    logic [23:0] body_length;
    logic [23:0] timestamp_ms;
    logic [31:0] trailer_size;

    modport source (
        output valid, tag_offset, tag_type, body_length, timestamp_ms, trailer_size,
        input  ready
    );

    modport sink (
        input  valid, tag_offset, tag_type, body_length, timestamp_ms, trailer_size,
        output ready
    );
endinterface

@@ src/flvtc_res_if.sv @@
interface flvtc_res_if;
    logic        valid;
    logic        ready;
    logic        tag_ok;
    logic [1:0]  error_code;
    logic [31:0] next_offset;
    logic        end_reached;
    logic        gap_found;
    logic [23:0] gap_ms;
    logic [4:0]  range_index;
    logic [23:0] range_min;
    logic [23:0] range_max;
    logic        range_overflow;

    modport source (
        output valid, tag_ok, error_code, next_offset, end_reached, gap_found, gap_ms,
               range_index, range_min, range_max, range_overflow,
        input  ready
    );

    modport sink (
        input  valid, tag_ok, error_code, next_offset, end_reached, gap_found, gap_ms,
               range_index, range_min, range_max, range_overflow,
        output ready
    );
endinterface

@@ src/flvtc_cfg_if.sv @@
interface flvtc_cfg_if;
    import flvtc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ src/flvtc_check.sv @@
module flvtc_check (
    input  flvtc_pkg::tag_item_t item,
    input  logic [31:0]          file_length,
    output flvtc_pkg::chk_res_t  chk
);
    import flvtc_pkg::*;

    logic [32:0] tag_end;
    logic [32:0] resync;
    logic [32:0] next_full;
    logic        type_ok;
    logic        past_end;
    logic        trailer_bad;
    logic        ok;

    assign tag_end = {1'b0, item.tag_offset} + {9'd0, item.body_length} + TAG_OVERHEAD;
    assign resync  = {1'b0, item.tag_offset} + 33'd1;

    assign type_ok = (item.tag_type == TYPE_AUDIO) || (item.tag_type == TYPE_VIDEO)
                  || (item.tag_type == TYPE_META);
    assign past_end    = tag_end > {1'b0, file_length};
    assign trailer_bad = item.trailer_size != ({8'd0, item.body_length} + TRAILER_DELTA);
    assign ok          = type_ok && !past_end && !trailer_bad;

    // end test uses the unwrapped 33-bit offset
    assign next_full = ok ? tag_end : resync;

    always_comb
    begin
        chk.tag_ok      = ok;
        chk.next_offset = next_full[31:0];
        chk.end_reached = next_full >= {1'b0, file_length};
        if (!type_ok)
        begin
            chk.error_code = ERR_TYPE;
        end
        else if (past_end)
        begin
            chk.error_code = ERR_END;
        end
        else if (trailer_bad)
        begin
            chk.error_code = ERR_TRAILER;
        end
        else
        begin
            chk.error_code = ERR_NONE;
        end
    end
endmodule

@@ src/flvtc_timeline.sv @@
`include "flv_tag_check_timeline_top_assert.svh"

module flvtc_timeline #(
    parameter int MAX_RANGES = flvtc_pkg::MAX_RANGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               tag_ok,
    input  logic [23:0]        timestamp_ms,
    input  logic [23:0]        gap_threshold,
    output flvtc_pkg::tl_res_t tl
);
    import flvtc_pkg::*;

    localparam int RW = (MAX_RANGES > 2) ? $clog2(MAX_RANGES) : 1;
    localparam logic [RW-1:0] LAST_RANGE = RW'(MAX_RANGES - 1);

    logic [23:0]   last_time_reg, last_time_next;
    logic          have_last_reg, have_last_next;
    logic [RW-1:0] cur_range_reg, cur_range_next;
    logic [23:0]   cur_min_reg, cur_min_next;
    logic [23:0]   cur_max_reg, cur_max_next;

    logic [23:0]   diff;
    logic          jump;
    logic          at_limit;
    logic          gap_found;
    logic          overflow;
    logic [RW+4:0] range_ext;

    assign diff     = timestamp_ms - last_time_reg;
    assign jump     = tag_ok && have_last_reg && (timestamp_ms > last_time_reg)
                   && (diff > gap_threshold);
    assign at_limit = cur_range_reg == LAST_RANGE;
    assign gap_found = jump && !at_limit;
    assign overflow  = jump && at_limit;

    always_comb
    begin
        last_time_next = last_time_reg;
        have_last_next = have_last_reg;
        cur_range_next = cur_range_reg;
        cur_min_next   = cur_min_reg;
        cur_max_next   = cur_max_reg;
        if (tag_ok)
        begin
            last_time_next = timestamp_ms;
            have_last_next = 1'b1;
            if (gap_found)
            begin
                cur_range_next = cur_range_reg + RW'(1);
                cur_min_next   = timestamp_ms;
                cur_max_next   = timestamp_ms;
            end
            else
            begin
                if (timestamp_ms < cur_min_reg)
                begin
                    cur_min_next = timestamp_ms;
                end
                if (timestamp_ms > cur_max_reg)
                begin
                    cur_max_next = timestamp_ms;
                end
            end
        end
    end

    assign range_ext = {5'd0, cur_range_next};

    always_comb
    begin
        tl.gap_found      = gap_found;
        tl.gap_ms         = jump ? diff : 24'd0;
        tl.range_index    = range_ext[4:0];
        tl.range_min      = cur_min_next;
        tl.range_max      = cur_max_next;
        tl.range_overflow = overflow;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            have_last_reg <= 1'b0;
            cur_range_reg <= '0;
            cur_min_reg   <= '0;
            cur_max_reg   <= '0;
        end
        else if (adv)
        begin
            last_time_reg <= last_time_next;
            have_last_reg <= have_last_next;
            cur_range_reg <= cur_range_next;
            cur_min_reg   <= cur_min_next;
            cur_max_reg   <= cur_max_next;
        end
    end

    `FLVTC_ASSERT_NEXT(a_range_step, adv && gap_found, cur_range_reg == $past(cur_range_reg) + RW'(1))
    `FLVTC_ASSERT_NOW(a_min_le_max, 1'b1, cur_min_reg <= cur_max_reg)
    `FLVTC_ASSERT_NOW(a_range_bound, 1'b1, cur_range_reg <= LAST_RANGE)
    `FLVTC_ASSERT_NEXT(a_hold_on_fail, adv && !tag_ok, $stable(last_time_reg) && $stable(cur_range_reg))
endmodule

@@ src/flv_tag_check_timeline_top.sv @@
// flv tag checker with timeline tracker
//
// tag: one beat per candidate tag (offset, type byte, body length, timestamp
//   and the trailer word found after the body); res: one beat per tag with
//   the check verdict, the next candidate offset and the time range state;
//   cfg: register writes, index 0 file length, index 1 gap threshold in ms.
// flow: a tag beat is taken into an input register, checked and tracked
//   there, and its result beat is registered when it leaves that register.
//   throughput is one tag per cycle while res takes its beats, with the
//   range registers (last time, range index, min, max) updated per result.
// reset: no range open yet, range 0 with min and max at 0, file length 0
//   and gap threshold 500 ms. cfg is always ready and is meant to be written
//   while no tag is in flight.
// stall: while res is held off, the result beat stays put and one more tag
//   beat is parked in the input register; after that tag.ready drops until
//   res takes the waiting beat. nothing is dropped or repeated.
module flv_tag_check_timeline_top #(
    parameter int MAX_RANGES = flvtc_pkg::MAX_RANGES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    flvtc_tag_if.sink    tag,
    flvtc_res_if.source  res,
    flvtc_cfg_if.sink    cfg
);
    import flvtc_pkg::*;

    logic [31:0] file_length_reg;
    logic [23:0] gap_thr_reg;

    logic        s1_valid_reg;
    tag_item_t   s1_reg;
    logic        out_valid_reg;
    chk_res_t    out_chk_reg;
    tl_res_t     out_tl_reg;

    logic        adv;
    logic        take;
    chk_res_t    chk;
    tl_res_t     tl;

    assign adv  = s1_valid_reg && (!out_valid_reg || res.ready);
    assign take = tag.valid && tag.ready;

    assign tag.ready = !s1_valid_reg || adv;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
            gap_thr_reg     <= GAP_THRESHOLD_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FILE_LENGTH:   file_length_reg <= cfg.data;
                CFG_GAP_THRESHOLD: gap_thr_reg     <= cfg.data[23:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_reg.tag_offset   <= tag.tag_offset;
            s1_reg.tag_type     <= tag.tag_type;
            s1_reg.body_length  <= tag.body_length;
            s1_reg.timestamp_ms <= tag.timestamp_ms;
            s1_reg.trailer_size <= tag.trailer_size;
        end
        if (adv)
        begin
            out_chk_reg <= chk;
            out_tl_reg  <= tl;
        end
    end

    flvtc_check u_check (
        .item        (s1_reg),
        .file_length (file_length_reg),
        .chk         (chk)
    );

    flvtc_timeline #(
        .MAX_RANGES (MAX_RANGES)
    ) u_timeline (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .tag_ok        (chk.tag_ok),
        .timestamp_ms  (s1_reg.timestamp_ms),
        .gap_threshold (gap_thr_reg),
        .tl            (tl)
    );

    assign res.valid          = out_valid_reg;
    assign res.tag_ok         = out_chk_reg.tag_ok;
    assign res.error_code     = out_chk_reg.error_code;
    assign res.next_offset    = out_chk_reg.next_offset;
    assign res.end_reached    = out_chk_reg.end_reached;
    assign res.gap_found      = out_tl_reg.gap_found;
    assign res.gap_ms         = out_tl_reg.gap_ms;
    assign res.range_index    = out_tl_reg.range_index;
    assign res.range_min      = out_tl_reg.range_min;
    assign res.range_max      = out_tl_reg.range_max;
    assign res.range_overflow = out_tl_reg.range_overflow;
endmodule
